// ===== design/spts_pkg.sv =====
// Shared types and constants of the stroke point thinning and subdivision block.
// No dependencies; used by every other file in this folder.
package spts_pkg;

  // input commands
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_MOTION  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // result kinds
  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_THICKEN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MOTION_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH_VARIATION = 2'd1;
  localparam logic [1:0] REG_PEN_WIDTH           = 2'd2;
  localparam logic [1:0] REG_PRESSURE_TOOL       = 2'd3;

  // shared unit widths
  localparam int MUL_W  = 25;   // multiplier operand
  localparam int PROD_W = 50;
  localparam int DIV_W  = 26;   // dividend / quotient
  localparam int DVS_W  = 16;   // divisor / remainder
  localparam int ROOT_W = 25;   // square root of a PROD_W value
  localparam int CNT_W  = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DISPATCH,
    ST_PRESS_OUT,
    ST_SQX,
    ST_SQY,
    ST_THR,
    ST_THICK_OUT,
    ST_DIVC,
    ST_SQRT,
    ST_DIVF,
    ST_DIVX,
    ST_DIVY,
    ST_DIVZ,
    ST_SUB,
    ST_FINAL,
    ST_REL_THICK,
    ST_REL_DUP
  } state_t;

endpackage

// ===== design/stroke_point_thinning_subdivider.sv =====
// Stroke point thinning and subdivision, top level: sequencer around one multiplier,
// one divider and one square root unit. Depends on spts_pkg, spts_mul, spts_div, spts_isqrt.
// A split motion runs a ceiling division, a square root and a floor division; if n > 1,
// three divisions by n (substep count) and n-1 substeps precede the final point.
// One transfer in at a time: s_tready is high only while the sequencer is idle; results
// wait in the output register, a stalled m_tready stalls the sequencer.
// Reset (rst, synchronous, active high): registers return to 77/77/512/1, stroke ended.
module stroke_point_thinning_subdivider #(
  parameter int MAX_SUBSTEPS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pos_x[23:0], pos_y[47:24], pressure[63:48]
  input  logic [2:0]  s_tuser,   // command[1:0], pressure_present[2]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_x[23:0], out_y[47:24], out_width[63:48]
  output logic [0:0]  m_tuser,   // kind[0]
  output logic        m_tlast,   // last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = $clog2(MAX_SUBSTEPS + 1);  // substep count width
  localparam int QW = spts_pkg::DIV_W;           // accumulator quotient width

  // ---------------- configuration ----------------
  logic [15:0] thr_reg, var_reg, pen_reg;
  logic        tool_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg  <= 16'd77;
      var_reg  <= 16'd77;
      pen_reg  <= 16'd512;
      tool_reg <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        spts_pkg::REG_MOTION_THRESHOLD:    thr_reg  <= cfg_data;
        spts_pkg::REG_MAX_WIDTH_VARIATION: var_reg  <= cfg_data;
        spts_pkg::REG_PEN_WIDTH:           pen_reg  <= cfg_data;
        spts_pkg::REG_PRESSURE_TOOL:       tool_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero reads as one
  logic [15:0] thr_e, var_e;
  assign thr_e = (thr_reg == '0) ? 16'd1 : thr_reg;
  assign var_e = (var_reg == '0) ? 16'd1 : var_reg;

  // ---------------- state ----------------
  spts_pkg::state_t state, state_next;

  logic        active, pmode;
  logic [1:0]  count;
  logic [23:0] lx, ly;
  logic [15:0] lw;

  // latched input transfer
  logic [23:0] inx, iny;
  logic [15:0] inp;
  logic        inpp;
  logic [1:0]  incmd;

  // working registers
  logic [15:0]                 zm;      // scaled motion width, or release width
  logic [15:0]                 hold_w;  // width of the duplicated lone point
  logic [spts_pkg::PROD_W-1:0] d2;
  logic [QW-1:0]               cq;      // ceil(|dz|/var)
  logic [SW-1:0]               n;       // substep count
  logic [SW-1:0]               k;
  logic signed [QW-1:0]        xqs, yqs, zqs;  // per-step quotient
  logic [SW-1:0]               xrs, yrs, zrs;  // per-step remainder
  logic signed [QW-1:0]        xq, yq, zq;     // running quotient
  logic [SW-1:0]               xr, yr, zr;     // running remainder

  // ---------------- shared units ----------------
  logic [spts_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [spts_pkg::PROD_W-1:0] prod;

  spts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  logic                       div_start, div_busy, div_done;
  logic [spts_pkg::DIV_W-1:0] div_a, div_q;
  logic [spts_pkg::DVS_W-1:0] div_b, div_r;

  spts_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  logic                        sq_start, sq_busy, sq_done;
  logic [spts_pkg::ROOT_W-1:0] sq_root;

  spts_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(d2),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  // ---------------- datapath decisions ----------------
  logic [15:0] zs;                // (pressure * pen_width) >> 16, valid in dispatch
  logic [24:0] dx, dy, ax, ay;
  logic [16:0] dz;
  logic [15:0] adz;
  logic        below, thick_ok, split;
  logic [15:0] rel_w, rel_nw;

  assign zs  = prod[31:16];
  assign dx  = {inx[23], inx} - {lx[23], lx};
  assign dy  = {iny[23], iny} - {ly[23], ly};
  assign ax  = dx[24] ? 25'(-dx) : dx;
  assign ay  = dy[24] ? 25'(-dy) : dy;
  assign dz  = {1'b0, zm} - {1'b0, lw};
  assign adz = dz[16] ? 16'(-dz) : dz[15:0];

  assign below    = d2 < prod;   // prod holds thr^2 in the compare state
  assign thick_ok = (count == 2'd1) && pmode && (lw < zm);
  assign split    = pmode && (adz > var_e);

  assign rel_w  = inpp ? zs : 16'd0;
  assign rel_nw = (rel_w > lw) ? rel_w : lw;

  // min(ceil, floor) clamped to 1..MAX_SUBSTEPS
  logic [QW-1:0] m_raw;
  logic [SW-1:0] m_clamp;
  assign m_raw   = (cq < div_q) ? cq : div_q;
  assign m_clamp = (m_raw > QW'(MAX_SUBSTEPS)) ? SW'(MAX_SUBSTEPS) :
                   (m_raw == '0) ? SW'(1) : m_raw[SW-1:0];

  // floor division fixup of an unsigned quotient/remainder
  logic          div_neg, div_rnz;
  logic signed [QW-1:0] fq;
  logic [SW-1:0] fr;
  always_comb begin
    case (state)
      spts_pkg::ST_DIVX: div_neg = dx[24];
      spts_pkg::ST_DIVY: div_neg = dy[24];
      default:           div_neg = dz[16];
    endcase
    div_rnz = (div_r != '0);
    if (div_neg && div_rnz) begin
      fq = -$signed(div_q + 1'b1);
      fr = n - div_r[SW-1:0];
    end else if (div_neg) begin
      fq = -$signed(div_q);
      fr = '0;
    end else begin
      fq = $signed(div_q);
      fr = div_r[SW-1:0];
    end
  end

  // one substep of q*n + r
  function automatic logic [QW+SW-1:0] step_acc(
    input logic signed [QW-1:0] q, input logic [SW-1:0] r,
    input logic signed [QW-1:0] dq, input logic [SW-1:0] dr,
    input logic [SW-1:0] nn
  );
    logic [SW:0]          rs;
    logic signed [QW-1:0] qn;
    logic [SW-1:0]        rn;
    rs = {1'b0, r} + {1'b0, dr};
    if (rs >= {1'b0, nn}) begin
      qn = q + dq + QW'(1);
      rn = SW'(rs - {1'b0, nn});
    end else begin
      qn = q + dq;
      rn = rs[SW-1:0];
    end
    return {qn, rn};
  endfunction

  logic [QW+SW-1:0] x_stp, y_stp, z_stp, z_init;
  assign x_stp  = step_acc(xq, xr, xqs, xrs, n);
  assign y_stp  = step_acc(yq, yr, yqs, yrs, n);
  assign z_stp  = step_acc(zq, zr, zqs, zrs, n);
  assign z_init = step_acc(fq, fr, fq, fr, n);   // dz at k = 2

  // saturating point count
  logic [2:0] cnt_sum;
  logic [1:0] cnt_new;
  assign cnt_sum = {1'b0, count} + {1'b0, n[1:0]};
  assign cnt_new = (n >= SW'(3) || cnt_sum > 3'd3) ? 2'd3 : cnt_sum[1:0];

  // ---------------- output register ----------------
  logic        out_free;
  logic        emit;
  logic        e_kind, e_last;
  logic [23:0] e_x, e_y;
  logic [15:0] e_w;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == spts_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      m_tdata <= {e_w, e_y, e_x};
      m_tuser <= e_kind;
      m_tlast <= e_last;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      spts_pkg::ST_IDLE:     if (s_tvalid) state_next = spts_pkg::ST_SCALE;
      spts_pkg::ST_SCALE:    state_next = spts_pkg::ST_DISPATCH;
      spts_pkg::ST_DISPATCH: begin
        case (incmd)
          spts_pkg::CMD_PRESS: state_next = spts_pkg::ST_PRESS_OUT;
          spts_pkg::CMD_MOTION: begin
            if (!active || (inpp && inp == '0)) state_next = spts_pkg::ST_IDLE;
            else state_next = spts_pkg::ST_SQX;
          end
          spts_pkg::CMD_RELEASE: begin
            if (!active || count != 2'd1) state_next = spts_pkg::ST_IDLE;
            else if (pmode) state_next = spts_pkg::ST_REL_THICK;
            else state_next = spts_pkg::ST_REL_DUP;
          end
          default: state_next = spts_pkg::ST_IDLE;
        endcase
      end
      spts_pkg::ST_SQX: state_next = spts_pkg::ST_SQY;
      spts_pkg::ST_SQY: state_next = spts_pkg::ST_THR;
      spts_pkg::ST_THR: begin
        if (below) state_next = thick_ok ? spts_pkg::ST_THICK_OUT : spts_pkg::ST_IDLE;
        else if (split) state_next = spts_pkg::ST_DIVC;
        else state_next = spts_pkg::ST_FINAL;
      end
      spts_pkg::ST_DIVC: if (div_done) state_next = spts_pkg::ST_SQRT;
      spts_pkg::ST_SQRT: if (sq_done) state_next = spts_pkg::ST_DIVF;
      spts_pkg::ST_DIVF: begin
        if (div_done) state_next = (m_clamp > SW'(1)) ? spts_pkg::ST_DIVX : spts_pkg::ST_FINAL;
      end
      spts_pkg::ST_DIVX: if (div_done) state_next = spts_pkg::ST_DIVY;
      spts_pkg::ST_DIVY: if (div_done) state_next = spts_pkg::ST_DIVZ;
      spts_pkg::ST_DIVZ: if (div_done) state_next = spts_pkg::ST_SUB;
      spts_pkg::ST_SUB: begin
        if (out_free && k == n - 1'b1) state_next = spts_pkg::ST_FINAL;
      end
      spts_pkg::ST_REL_THICK: if (out_free) state_next = spts_pkg::ST_REL_DUP;
      spts_pkg::ST_PRESS_OUT,
      spts_pkg::ST_THICK_OUT,
      spts_pkg::ST_FINAL,
      spts_pkg::ST_REL_DUP: if (out_free) state_next = spts_pkg::ST_IDLE;
      default: state_next = spts_pkg::ST_IDLE;
    endcase
  end

  // ---------------- unit controls and result fields ----------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    sq_start  = 1'b0;
    emit      = 1'b0;
    e_kind    = spts_pkg::KIND_ADD;
    e_last    = 1'b1;
    e_x       = lx;
    e_y       = ly;
    e_w       = lw;
    case (state)
      spts_pkg::ST_SCALE: begin
        mul_a = spts_pkg::MUL_W'(inp);
        mul_b = spts_pkg::MUL_W'(pen_reg);
      end
      spts_pkg::ST_DISPATCH: begin
        mul_a = ax;
        mul_b = ax;
      end
      spts_pkg::ST_SQX: begin
        mul_a = ay;
        mul_b = ay;
      end
      spts_pkg::ST_SQY: begin
        mul_a = spts_pkg::MUL_W'(thr_e);
        mul_b = spts_pkg::MUL_W'(thr_e);
      end
      spts_pkg::ST_DIVC: begin
        div_start = !div_busy && !div_done;
        div_a     = spts_pkg::DIV_W'({1'b0, adz} + {1'b0, var_e} - 17'd1);
        div_b     = var_e;
      end
      spts_pkg::ST_SQRT: sq_start = !sq_busy && !sq_done;
      spts_pkg::ST_DIVF: begin
        div_start = !div_busy && !div_done;
        div_a     = spts_pkg::DIV_W'(sq_root);
        div_b     = thr_e;
      end
      spts_pkg::ST_DIVX: begin
        div_start = !div_busy && !div_done;
        div_a     = spts_pkg::DIV_W'(ax);
        div_b     = spts_pkg::DVS_W'(n);
      end
      spts_pkg::ST_DIVY: begin
        div_start = !div_busy && !div_done;
        div_a     = spts_pkg::DIV_W'(ay);
        div_b     = spts_pkg::DVS_W'(n);
      end
      spts_pkg::ST_DIVZ: begin
        div_start = !div_busy && !div_done;
        div_a     = spts_pkg::DIV_W'(adz);
        div_b     = spts_pkg::DVS_W'(n);
      end
      spts_pkg::ST_PRESS_OUT: emit = 1'b1;
      spts_pkg::ST_THICK_OUT: begin
        emit   = 1'b1;
        e_kind = spts_pkg::KIND_THICKEN;
      end
      spts_pkg::ST_SUB: begin
        emit   = 1'b1;
        e_last = 1'b0;
        e_x    = lx + xq[23:0];
        e_y    = ly + yq[23:0];
        e_w    = lw + zq[15:0];
      end
      spts_pkg::ST_FINAL: begin
        emit = 1'b1;
        e_x  = inx;
        e_y  = iny;
        e_w  = zm;
      end
      spts_pkg::ST_REL_THICK: begin
        emit   = 1'b1;
        e_kind = spts_pkg::KIND_THICKEN;
        e_last = 1'b0;
        e_w    = zm;
      end
      spts_pkg::ST_REL_DUP: begin
        emit = 1'b1;
        e_w  = hold_w;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= spts_pkg::ST_IDLE;
      active <= 1'b0;
      pmode  <= 1'b0;
      count  <= '0;
      lx     <= '0;
      ly     <= '0;
      lw     <= '0;
    end else begin
      state <= state_next;
      case (state)
        spts_pkg::ST_DISPATCH: begin
          case (incmd)
            spts_pkg::CMD_PRESS: begin
              active <= 1'b1;
              pmode  <= tool_reg && inpp;
              lx     <= inx;
              ly     <= iny;
              lw     <= (tool_reg && inpp) ? zs : 16'd0;
              count  <= 2'd1;
            end
            spts_pkg::CMD_RELEASE: begin
              // a lone point is duplicated first; the stroke ends after it
              if (active && count != 2'd1) begin
                active <= 1'b0;
                count  <= '0;
              end
            end
            default: ;
          endcase
        end
        spts_pkg::ST_THR: if (below && thick_ok) lw <= zm;
        spts_pkg::ST_FINAL: begin
          if (out_free) begin
            lx    <= inx;
            ly    <= iny;
            lw    <= zm;
            count <= cnt_new;
          end
        end
        spts_pkg::ST_REL_THICK: if (out_free) lw <= zm;
        spts_pkg::ST_REL_DUP: begin
          if (out_free) begin
            active <= 1'b0;
            count  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (state)
      spts_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          inx   <= s_tdata[23:0];
          iny   <= s_tdata[47:24];
          inp   <= s_tdata[63:48];
          incmd <= s_tuser[1:0];
          inpp  <= s_tuser[2];
        end
      end
      spts_pkg::ST_DISPATCH: begin
        hold_w <= lw;
        if (incmd == spts_pkg::CMD_RELEASE) zm <= rel_nw;
        else zm <= (pmode && inpp) ? zs : 16'd0;
      end
      spts_pkg::ST_SQX: d2 <= prod;
      spts_pkg::ST_SQY: d2 <= d2 + prod;
      spts_pkg::ST_THR: n <= SW'(1);
      spts_pkg::ST_DIVC: if (div_done) cq <= div_q;
      spts_pkg::ST_DIVF: if (div_done) n <= m_clamp;
      spts_pkg::ST_DIVX: begin
        if (div_done) begin
          xqs <= fq;
          xrs <= fr;
          xq  <= fq;
          xr  <= fr;
        end
      end
      spts_pkg::ST_DIVY: begin
        if (div_done) begin
          yqs <= fq;
          yrs <= fr;
          yq  <= fq;
          yr  <= fr;
        end
      end
      spts_pkg::ST_DIVZ: begin
        if (div_done) begin
          zqs <= fq;
          zrs <= fr;
          zq  <= z_init[QW+SW-1:SW];
          zr  <= z_init[SW-1:0];
          k   <= SW'(1);
        end
      end
      spts_pkg::ST_SUB: begin
        if (out_free) begin
          xq <= x_stp[QW+SW-1:SW];
          xr <= x_stp[SW-1:0];
          yq <= y_stp[QW+SW-1:SW];
          yr <= y_stp[SW-1:0];
          zq <= z_stp[QW+SW-1:SW];
          zr <= z_stp[SW-1:0];
          k  <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/spts_mul.sv =====
// Registered unsigned multiplier shared by the sequencer.
// Depends on spts_pkg.
module spts_mul (
  input  logic                           clk,
  input  logic [spts_pkg::MUL_W-1:0]     a,
  input  logic [spts_pkg::MUL_W-1:0]     b,
  output logic [spts_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== design/spts_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spts_pkg.
module spts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spts_pkg::DIV_W-1:0]    dividend,
  input  logic [spts_pkg::DVS_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [spts_pkg::DIV_W-1:0]    quotient,
  output logic [spts_pkg::DVS_W-1:0]    remainder
);

  logic [spts_pkg::DVS_W-1:0] dvs;
  logic [spts_pkg::CNT_W-1:0] cnt;
  logic [spts_pkg::DVS_W:0]   shifted;
  logic [spts_pkg::DVS_W:0]   diff;
  logic                       ge;

  assign shifted = {remainder, quotient[spts_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= spts_pkg::CNT_W'(spts_pkg::DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[spts_pkg::DIV_W-2:0], ge};
      remainder <= ge ? diff[spts_pkg::DVS_W-1:0] : shifted[spts_pkg::DVS_W-1:0];
    end
  end

endmodule

// ===== design/spts_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on spts_pkg.
module spts_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spts_pkg::PROD_W-1:0]   radicand,
  output logic                          busy,
  output logic                          done,
  output logic [spts_pkg::ROOT_W-1:0]   root
);

  localparam int REM_W = spts_pkg::ROOT_W + 1;

  logic [spts_pkg::PROD_W-1:0] v;
  logic [REM_W-1:0]            rem;
  logic [spts_pkg::CNT_W-1:0]  cnt;
  logic [REM_W+1:0]            nxt;
  logic [REM_W+1:0]            trial;
  logic                        ge;

  assign nxt   = {rem, v[spts_pkg::PROD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = nxt >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= spts_pkg::CNT_W'(spts_pkg::ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      v    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v    <= {v[spts_pkg::PROD_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(nxt - trial) : REM_W'(nxt);
      root <= {root[spts_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== bench/spts_checker.sv =====
// Result checker for the stroke point thinning and subdivision block: follows the input,
// config and result channels, predicts each result and compares it. Depends on spts_pkg.
module spts_checker
  import spts_pkg::*;
#(
  parameter int MAX_SUBSTEPS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        kind;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] wd;
    logic        lst;
  } point_t;

  point_t point_q[$];

  logic [15:0] thr_reg, var_reg, pen_reg;
  logic        tool_reg;
  logic        in_stroke, pmode;
  int          npoints;
  longint      lx, ly, lw;

  assign pending = point_q.size();

  function automatic longint width_of(longint p);
    return ((p * pen_reg) >>> 16) & 64'hFFFF;
  endfunction

  function automatic longint root_of(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) r += longint'(1) << b;
    return r;
  endfunction

  function automatic longint fdiv(longint a, longint n);
    longint q;
    q = a / n;
    if ((a % n) != 0 && a < 0) q--;
    return q;
  endfunction

  task automatic push_point(logic kind, longint x, longint y, longint w);
    point_t e;
    e.kind = kind;
    e.px   = x[23:0];
    e.py   = y[23:0];
    e.wd   = w[15:0];
    e.lst  = 1'b0;
    point_q.push_back(e);
  endtask

  task automatic mark_last();
    point_t e;
    e = point_q.pop_back();
    e.lst = 1'b1;
    point_q.push_back(e);
  endtask

  task automatic predict_event(logic [1:0] cmd, longint x, longint y, longint p, logic pp);
    longint thr, vr, z, dx, dy, d2, dz, adz, c, f, m, steps, rw, old;
    thr = thr_reg == 0 ? 1 : thr_reg;
    vr  = var_reg == 0 ? 1 : var_reg;
    steps = 1;
    case (cmd)
      CMD_PRESS: begin
        in_stroke = 1'b1;
        pmode = tool_reg && pp;
        lx = x;
        ly = y;
        lw = pmode ? width_of(p) : 0;
        npoints = 1;
        push_point(KIND_ADD, x, y, lw);
        mark_last();
      end
      CMD_MOTION: begin
        if (!in_stroke || (pp && p == 0)) return;
        z = (pmode && pp) ? width_of(p) : 0;
        dx = x - lx;
        dy = y - ly;
        d2 = dx * dx + dy * dy;
        if (d2 < thr * thr) begin
          // near point may only thicken a lone first point
          if (npoints == 1 && pmode && lw < z) begin
            lw = z;
            push_point(KIND_THICKEN, lx, ly, z);
            mark_last();
          end
          return;
        end
        if (pmode) begin
          dz = z - lw;
          adz = dz < 0 ? -dz : dz;
          if (adz > vr) begin
            c = (adz + vr - 1) / vr;
            f = root_of(d2) / thr;
            m = c < f ? c : f;
            if (m > MAX_SUBSTEPS) m = MAX_SUBSTEPS;
            if (m < 1) m = 1;
            steps = m;
            // width leads position by one step
            for (longint k = 1; k < steps; k++)
              push_point(KIND_ADD, lx + fdiv(dx * k, steps), ly + fdiv(dy * k, steps),
                         lw + fdiv(dz * (k + 1), steps));
          end
        end
        push_point(KIND_ADD, x, y, pmode ? z : 0);
        mark_last();
        lx = x;
        ly = y;
        lw = pmode ? z : 0;
        npoints = npoints + steps > 3 ? 3 : npoints + int'(steps);
      end
      CMD_RELEASE: begin
        if (!in_stroke) return;
        if (npoints == 1) begin
          old = lw;
          if (pmode) begin
            rw = pp ? width_of(p) : 0;
            lw = rw > old ? rw : old;
            push_point(KIND_THICKEN, lx, ly, lw);
          end
          push_point(KIND_ADD, lx, ly, old);
          mark_last();
        end
        in_stroke = 1'b0;
        npoints = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    point_t e, got;
    if (rst) begin
      thr_reg   <= 16'd77;
      var_reg   <= 16'd77;
      pen_reg   <= 16'd512;
      tool_reg  <= 1'b1;
      in_stroke = 1'b0;
      pmode     = 1'b0;
      npoints   = 0;
      lx = 0;
      ly = 0;
      lw = 0;
      errors    <= 0;
      point_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOTION_THRESHOLD:    thr_reg  <= cfg_data;
          REG_MAX_WIDTH_VARIATION: var_reg  <= cfg_data;
          REG_PEN_WIDTH:           pen_reg  <= cfg_data;
          REG_PRESSURE_TOOL:       tool_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_event(s_tuser[1:0], longint'($signed(s_tdata[23:0])),
                      longint'($signed(s_tdata[47:24])), longint'(s_tdata[63:48]), s_tuser[2]);
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[23:0], m_tdata[47:24], m_tdata[63:48], m_tlast};
        if (point_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          e = point_q.pop_front();
          if (e !== got) begin
            $display("%0t: result mismatch, expected kind %0d x %h y %h w %h last %0d, actual kind %0d x %h y %h w %h last %0d",
                     $time, e.kind, e.px, e.py, e.wd, e.lst,
                     got.kind, got.px, got.py, got.wd, got.lst);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the stroke point thinning and subdivision bench: clock, reset, stylus event
// stimulus, config phases and verdict. Depends on spts_pkg, spts_checker and the block.
module testbench;
  import spts_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;    // pos_x[23:0], pos_y[47:24], pressure[63:48]
  logic [2:0]  s_tuser;    // command[1:0], pressure_present[2]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;    // out_x[23:0], out_y[47:24], out_width[63:48]
  logic [0:0]  m_tuser;    // kind[0]
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;

  // current pen position, so motions stay near the stroke
  int          pen_x, pen_y;

  stroke_point_thinning_subdivider dut (.*);

  spts_checker chk (.*);

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, some long, with stall-free stretches
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 3) != 0;
        default: m_tready <= $urandom_range(0, 15) == 0;
      endcase
    end
  end

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 7 ? $urandom_range(0, 2) : $urandom_range(5, 40);
    repeat (n) @(posedge clk);
  endtask

  // one transfer on the event channel
  task automatic send_event(logic [1:0] cmd, int x, int y, int p, logic pp);
    s_tvalid <= 1'b1;
    s_tdata  <= {p[15:0], y[23:0], x[23:0]};
    s_tuser  <= {pp, cmd};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    if (cmd == CMD_PRESS || cmd == CMD_MOTION) begin
      pen_x = x;
      pen_y = y;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then let a split motion finish before config changes
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic config_all(logic [15:0] thr, logic [15:0] vr, logic [15:0] pen,
                            logic tool);
    write_reg(REG_MOTION_THRESHOLD, thr);
    write_reg(REG_MAX_WIDTH_VARIATION, vr);
    write_reg(REG_PEN_WIDTH, pen);
    write_reg(REG_PRESSURE_TOOL, tool);
  endtask

  // mostly well-formed strokes with random content; some noise
  task automatic random_items(int count, int step);
    int r, x, y;
    for (int i = 0; i < count; i++) begin
      idle_gap();
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_event(CMD_PRESS, $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                   $urandom, $urandom_range(0, 5) != 0);
      end else if (r < 82) begin
        x = pen_x + $urandom_range(0, 2 * step) - step;
        y = pen_y + $urandom_range(0, 2 * step) - step;
        send_event(CMD_MOTION, x, y, $urandom_range(0, 9) == 0 ? 0 : $urandom,
                   $urandom_range(0, 7) != 0);
      end else if (r < 92) begin
        send_event(CMD_RELEASE, pen_x, pen_y, $urandom, $urandom_range(0, 1));
      end else if (r < 96) begin
        send_event(2'd3, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
        // far jumps exercise the coordinate extremes
        send_event(CMD_MOTION, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    pen_x = 0;
    pen_y = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset configuration
    send_event(CMD_MOTION, 5, 5, 100, 1);          // no stroke: ignored
    send_event(CMD_RELEASE, 0, 0, 0, 0);           // no stroke: ignored
    send_event(2'd3, 1, 1, 1, 1);                  // unused command
    send_event(CMD_PRESS, 0, 0, 16'h1000, 1);
    send_event(CMD_MOTION, 10, 10, 16'hC000, 1);   // near point thickens lone point
    send_event(CMD_MOTION, 10, 10, 0, 1);          // present with zero pressure
    send_event(CMD_RELEASE, 0, 0, 16'hFFFF, 1);    // lone point release, thicken first
    send_event(CMD_PRESS, 100, 100, 16'h0100, 1);
    send_event(CMD_PRESS, -8388608, 8388607, 16'h0100, 1); // press during stroke
    send_event(CMD_MOTION, 8388607, -8388608, 16'hFFFF, 1); // extreme split
    send_event(CMD_MOTION, 8388000, -8388000, 16'h0001, 1);
    send_event(CMD_MOTION, 0, 0, 16'hFFFF, 0);     // pressure mode, no pressure
    send_event(CMD_RELEASE, 0, 0, 0, 0);
    send_event(CMD_PRESS, 0, 0, 16'h8000, 0);      // no pressure mode
    send_event(CMD_RELEASE, 0, 0, 0, 1);           // lone point duplicate
    // pause until all results are in
    drain();

    // extremes: thresholds zero (read as one) and tool off
    config_all(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_event(CMD_PRESS, 0, 0, 16'hFFFF, 1);
    send_event(CMD_MOTION, 1, 0, 16'hFFFF, 1);
    send_event(CMD_RELEASE, 0, 0, 0, 0);
    drain();
    config_all(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_event(CMD_PRESS, 0, 0, 16'h0001, 1);
    send_event(CMD_MOTION, 5000, 0, 16'hFFFF, 1);  // capped at substep limit
    send_event(CMD_MOTION, 5000, 3, 16'h0002, 1);
    send_event(CMD_RELEASE, 0, 0, 0, 0);
    drain();

    config_all(16'd77, 16'd77, 16'd512, 1'b1);
    random_items(90, 400);
    drain();
    config_all(16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
    random_items(30, 300000);
    drain();
    config_all(16'd200, 16'd40, 16'd3000, 1'b1);
    random_items(90, 2500);
    drain();
    config_all(16'd30, 16'd300, 16'd800, 1'b0);
    random_items(25, 200);

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
